### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/bsst_pkg.sv
// ----------------------------------------------------------------------------
// bsst_pkg
// Types, constants and microcode table of the sorted-table search core.
// ----------------------------------------------------------------------------
package bsst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int TBL_BW      = TBL_AW + 2;   // signed low/high bounds
  localparam int CFG_W       = 9;
  localparam int DATA_W      = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [7:0]               entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] match_index;
  } out_result_t;

  // microcode step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_CHECK = 3'd1;
  localparam step_t STEP_CMP   = 3'd2;
  localparam step_t STEP_HIT   = 3'd3;
  localparam step_t STEP_MISS  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_PROBE = 3'd2,
    OP_STEP  = 3'd3,
    OP_HIT   = 3'd4,
    OP_MISS  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_START  = 2'd1,
    COND_EMPTY  = 2'd2,
    COND_EQ     = 2'd3
  } cond_t;

  typedef struct packed {
    logic  busy;
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctrl_word_t;

  typedef struct packed {
    logic start_search;
    logic empty;
    logic eq;
  } flags_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    case (step)
      STEP_IDLE:  w = '{busy: 1'b0, op: OP_LOAD,  cond: COND_START,
                        tgt_true: STEP_CHECK, tgt_false: STEP_IDLE};
      STEP_CHECK: w = '{busy: 1'b1, op: OP_PROBE, cond: COND_EMPTY,
                        tgt_true: STEP_MISS,  tgt_false: STEP_CMP};
      STEP_CMP:   w = '{busy: 1'b1, op: OP_STEP,  cond: COND_EQ,
                        tgt_true: STEP_HIT,   tgt_false: STEP_CHECK};
      STEP_HIT:   w = '{busy: 1'b1, op: OP_HIT,   cond: COND_ALWAYS,
                        tgt_true: STEP_IDLE,  tgt_false: STEP_IDLE};
      STEP_MISS:  w = '{busy: 1'b1, op: OP_MISS,  cond: COND_ALWAYS,
                        tgt_true: STEP_IDLE,  tgt_false: STEP_IDLE};
      default:    w = '{busy: 1'b1, op: OP_NONE,  cond: COND_ALWAYS,
                        tgt_true: STEP_IDLE,  tgt_false: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### sv/bsst_ram.sv
// ----------------------------------------------------------------------------
// bsst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/bsst_seq.sv
// ----------------------------------------------------------------------------
// bsst_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module bsst_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  bsst_pkg::flags_t    flags,
  output bsst_pkg::ctrl_word_t ctrl
);
  import bsst_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  cond_hit;

  assign ctrl = ucode_rom(step_r);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS: cond_hit = 1'b1;
      COND_START:  cond_hit = flags.start_search;
      COND_EMPTY:  cond_hit = flags.empty;
      COND_EQ:     cond_hit = flags.eq;
      default:     cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? ctrl.tgt_true : ctrl.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### sv/bsst_dpath.sv
// ----------------------------------------------------------------------------
// bsst_dpath
// Search datapath: low/high bounds, midpoint, key compare.
// ----------------------------------------------------------------------------
module bsst_dpath (
  input  logic                            clk,
  input  bsst_pkg::op_t                   op,
  input  logic [bsst_pkg::CFG_W-1:0]      cfg_entries,
  input  logic [bsst_pkg::DATA_W-1:0]     key_in,
  input  logic [bsst_pkg::DATA_W-1:0]     rdata,
  output logic [bsst_pkg::TBL_AW-1:0]     probe_addr,
  output logic                            empty,
  output logic                            eq,
  output logic [bsst_pkg::TBL_AW-1:0]     mid_q
);
  import bsst_pkg::*;

  logic signed [TBL_BW-1:0] low_r,  low_nxt;
  logic signed [TBL_BW-1:0] high_r, high_nxt;
  logic [DATA_W-1:0]        key_r,  key_nxt;
  logic [TBL_AW-1:0]        mid_r,  mid_nxt;
  logic [TBL_BW-1:0]        sum;
  logic [TBL_BW-1:0]        len_sat;
  logic                     below;

  // clamp the entry count to the table depth
  assign len_sat = (32'(cfg_entries) > 32'(TABLE_DEPTH)) ? TBL_BW'(TABLE_DEPTH)
                                                         : TBL_BW'(cfg_entries);

  // bounds are non-negative whenever the search range is not empty
  assign sum        = TBL_BW'(low_r) + TBL_BW'(high_r);
  assign probe_addr = sum[TBL_AW:1];

  assign empty = (low_r > high_r);
  assign eq    = (rdata == key_r);
  assign below = ($signed(rdata) < $signed(key_r));
  assign mid_q = mid_r;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    key_nxt  = key_r;
    mid_nxt  = mid_r;
    case (op)
      OP_LOAD: begin
        low_nxt  = '0;
        high_nxt = len_sat - TBL_BW'(1);
        key_nxt  = key_in;
      end
      OP_PROBE: begin
        mid_nxt = probe_addr;
      end
      OP_STEP: begin
        if (below) begin
          low_nxt = TBL_BW'(mid_r) + TBL_BW'(1);
        end else begin
          high_nxt = TBL_BW'(mid_r) - TBL_BW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
    key_r  <= key_nxt;
    mid_r  <= mid_nxt;
  end

endmodule

### sv/binary_search_sorted_table_core.sv
// ----------------------------------------------------------------------------
// binary_search_sorted_table_core
// Table of signed 32-bit entries with a microcoded binary search.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A write
// transaction (mode 0) stores entry_value at entry_index in the same edge,
// keeps busy low and gives no result, so writes can go every cycle. A search
// transaction (mode 1) raises busy and returns exactly one result, shown for
// a single cycle with out_valid; the receiver cannot stall it, so sample it
// when out_valid is high. Each probe is a table RAM read with registered
// data, then a compare. A search covering N entries takes P probes, with
// P <= floor(log2(N)) + 1. The result is shown in the cycle after busy
// drops, and a new transaction may be taken in that same cycle.
// entries_in_use (reset 256, clamped to the table depth) is written over the
// cfg channel, which is always ready; change it only while no search is in
// flight. Searching entries never written since reset gives an undefined
// answer.
// ----------------------------------------------------------------------------
module binary_search_sorted_table_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bsst_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output bsst_pkg::out_result_t        out_result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsst_pkg::CFG_W-1:0]   cfg_entries_in_use
);
  import bsst_pkg::*;

  ctrl_word_t          ctrl;
  flags_t              flags;
  logic [CFG_W-1:0]    cfg_entries_r, cfg_entries_nxt;
  logic                out_valid_r,   out_valid_nxt;
  out_result_t         out_result_r,  out_result_nxt;
  logic                accept;
  logic                wr_en;
  logic [TBL_AW-1:0]   probe_addr;
  logic [TBL_AW-1:0]   mid_q;
  logic [DATA_W-1:0]   rdata;
  logic                empty;
  logic                eq;

  // handshake
  assign busy      = ctrl.busy;
  assign accept    = start & ~ctrl.busy;
  assign cfg_ready = 1'b1;

  // writes beyond the table are dropped
  assign wr_en = accept & (in_item.mode == MODE_WRITE)
               & (32'(in_item.entry_index) < 32'(TABLE_DEPTH));

  assign flags = '{start_search: accept & (in_item.mode == MODE_SEARCH),
                   empty:        empty,
                   eq:           eq};

  bsst_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  bsst_dpath u_dpath (
    .clk         (clk),
    .op          (ctrl.op),
    .cfg_entries (cfg_entries_r),
    .key_in      (in_item.search_key),
    .rdata       (rdata),
    .probe_addr  (probe_addr),
    .empty       (empty),
    .eq          (eq),
    .mid_q       (mid_q)
  );

  bsst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (TBL_AW'(in_item.entry_index)),
    .wdata (in_item.entry_value),
    .raddr (probe_addr),
    .rdata (rdata)
  );

  // config register and result strobe
  always_comb begin
    cfg_entries_nxt = cfg_valid ? cfg_entries_in_use : cfg_entries_r;
    out_valid_nxt   = (ctrl.op == OP_HIT) || (ctrl.op == OP_MISS);
    out_result_nxt  = out_result_r;
    if (ctrl.op == OP_HIT) begin
      out_result_nxt = '{found: 1'b1, match_index: 8'(mid_q)};
    end else if (ctrl.op == OP_MISS) begin
      out_result_nxt = '{found: 1'b0, match_index: 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= CFG_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      cfg_entries_r <= cfg_entries_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

### sv/bsst_checker.sv
// ----------------------------------------------------------------------------
// bsst_checker
// Port-level checks of the search core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsst_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input bsst_pkg::in_item_t         in_item,
  input logic                       out_valid,
  input bsst_pkg::out_result_t      out_result
);
  import bsst_pkg::*;

  logic wr_take;
  logic srch_take;
  logic miss_shown;

  assign wr_take    = start && !busy && (in_item.mode == MODE_WRITE);
  assign srch_take  = start && !busy && (in_item.mode == MODE_SEARCH);
  assign miss_shown = out_valid && !out_result.found;

  `AST_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `AST_IMPLIES(a_miss_index_zero, clk, rst_n, miss_shown, out_result.match_index == 8'd0)
  `AST_NEXT(a_write_no_busy, clk, rst_n, wr_take, !busy && !out_valid)
  `AST_NEXT(a_search_busy, clk, rst_n, srch_take, busy)
  `AST_IMPLIES(a_result_after_busy, clk, rst_n, out_valid, $past(busy) && !busy)

endmodule

bind binary_search_sorted_table_core bsst_checker u_bsst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_valid  (out_valid),
  .out_result (out_result)
);
